// File: rtl/lpt_pkg.sv
// Shared types and codes for the IPv4 longest-prefix trie.
// No dependencies; imported by the interfaces, the top level and the checker.
package lpt_pkg;

   localparam int ADDR_BITS = 32;
   localparam int LVL_W     = 6;   // holds a level from 0 to 32

   // request codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_POP,
      S_LINK,
      S_INIT,
      S_READ,
      S_LREQ,
      S_LDATA,
      S_DCHECK,
      S_DPARENT,
      S_DPEVAL,
      S_FINISH
   } state_type;

endpackage

// File: rtl/lpt_if.sv
// Request and response channel interfaces for the prefix trie.
// Depends on lpt_pkg for the address width.
interface lpt_req_if;
   import lpt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [ADDR_BITS-1:0] address;
   logic [ADDR_BITS-1:0] net_mask;
   logic [ADDR_BITS-1:0] hop_tag;

   modport source (output valid, req_type, address, net_mask, hop_tag, input ready);
   modport sink   (input valid, req_type, address, net_mask, hop_tag, output ready);
endinterface

interface lpt_rsp_if;
   import lpt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic                 found;
   logic [ADDR_BITS-1:0] match_prefix;
   logic [ADDR_BITS-1:0] match_mask;
   logic [ADDR_BITS-1:0] match_hop;

   modport source (output valid, status, found, match_prefix, match_mask, match_hop,
                   input ready);
   modport sink   (input valid, status, found, match_prefix, match_mask, match_hop,
                   output ready);
endinterface

// File: rtl/lpt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/ipv4_longest_prefix_trie_top.sv
// Top level of the IPv4 longest-prefix trie: control sequencer and memories.
// Depends on lpt_pkg, lpt_if (channels) and lpt_ram.

// One request is handled at a time; each trie level costs one node memory read.
// After reset a clearing pass zeroes the node memory and fills the free stack;
// no request is taken until it ends. A lookup walks down the prefix depth and
// then reads the best route found, if any. An insert walks its prefix length
// and creates a node for each level that is missing. A delete walks down its
// prefix length, then frees each empty node on the way back up. The response
// sits in an output register, so a new request is taken while the previous
// response waits.
module ipv4_longest_prefix_trie_top #(
   parameter int NODE_COUNT = 1024
) (
   input  logic         clock,
   input  logic         reset,
   lpt_req_if.sink      req_chan,
   lpt_rsp_if.source    rsp_chan
);
   import lpt_pkg::*;

   localparam int IW = $clog2(NODE_COUNT);
   localparam int NW = 2 * IW + 1;
   localparam int RW = 3 * ADDR_BITS;

   state_type state_ff, state_in;

   logic [1:0]           op_ff, op_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in, mask_ff, mask_in, hop_ff, hop_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic [IW-1:0]        cur_ff, cur_in, best_ff, best_in, new_ff, new_in;
   logic [IW-1:0]        cnt_ff, cnt_in, clr_ff, clr_in;
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        left_ff, left_in, right_ff, right_in;
   logic                 valid_ff, valid_in;

   logic [1:0]           res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   logic [ADDR_BITS-1:0] res_pfx_ff, res_pfx_in, res_mask_ff, res_mask_in;
   logic [ADDR_BITS-1:0] res_hop_ff, res_hop_in;

   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           out_status_ff, out_status_in;
   logic                 out_found_ff, out_found_in;
   logic [ADDR_BITS-1:0] out_pfx_ff, out_pfx_in, out_mask_ff, out_mask_in;
   logic [ADDR_BITS-1:0] out_hop_ff, out_hop_in;

   // memory ports
   logic          node_we;
   logic [IW-1:0] node_waddr, node_raddr;
   logic [NW-1:0] node_wdata, node_rdata;
   logic          route_we;
   logic [RW-1:0] route_wdata, route_rdata;
   logic          stack_we;
   logic [IW-1:0] stack_waddr, stack_raddr, stack_wdata, stack_rdata;
   logic          path_we;
   logic [4:0]    path_waddr, path_raddr;
   logic [IW-1:0] path_rdata;

   logic [IW-1:0] n_left, n_right, child;
   logic          n_valid, dir_bit, end_look, end_route, accept, out_free;
   logic [4:0]    bit_idx;

   assign {n_left, n_right, n_valid} = node_rdata;
   assign bit_idx   = 5'd31 - lvl_ff[4:0];
   assign dir_bit   = addr_ff[bit_idx];
   assign child     = dir_bit ? n_right : n_left;
   assign end_look  = lvl_ff[5];
   assign end_route = lvl_ff[5] | ~mask_ff[bit_idx];
   assign accept    = req_chan.valid && (state_ff == S_IDLE);
   assign out_free  = !out_valid_ff || rsp_chan.ready;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.found        = out_found_ff;
   assign rsp_chan.match_prefix = out_pfx_ff;
   assign rsp_chan.match_mask   = out_mask_ff;
   assign rsp_chan.match_hop    = out_hop_ff;

   // memories: node links and valid, routes, free stack, delete path
   lpt_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_node (
      .clock(clock), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
      .rd_addr(node_raddr), .rd_data(node_rdata));
   lpt_ram #(.WIDTH(RW), .DEPTH(NODE_COUNT)) u_route (
      .clock(clock), .wr_en(route_we), .wr_addr(cur_ff), .wr_data(route_wdata),
      .rd_addr(best_ff), .rd_data(route_rdata));
   lpt_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_stack (
      .clock(clock), .wr_en(stack_we), .wr_addr(stack_waddr), .wr_data(stack_wdata),
      .rd_addr(stack_raddr), .rd_data(stack_rdata));
   lpt_ram #(.WIDTH(IW), .DEPTH(32)) u_path (
      .clock(clock), .wr_en(path_we), .wr_addr(path_waddr), .wr_data(cur_ff),
      .rd_addr(path_raddr), .rd_data(path_rdata));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:   if (clr_ff == IW'(NODE_COUNT - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (req_chan.req_type inside {OP_INSERT, OP_LOOKUP, OP_DELETE}) begin
                  state_in = S_EVAL;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_EVAL: begin
            if (op_ff == OP_LOOKUP) begin
               if (end_look || child == '0) begin
                  state_in = (hit_ff || n_valid) ? S_LREQ : S_FINISH;
               end
            end else if (op_ff == OP_INSERT) begin
               if (end_route) state_in = S_FINISH;
               else if (child == '0) state_in = (cnt_ff == '0) ? S_FINISH : S_POP;
            end else begin
               if (end_route) state_in = n_valid ? S_DCHECK : S_FINISH;
               else if (child == '0) state_in = S_FINISH;
            end
         end
         S_POP:     state_in = S_LINK;
         S_LINK:    state_in = S_INIT;
         S_INIT:    state_in = S_READ;
         S_READ:    state_in = S_EVAL;
         S_LREQ:    state_in = S_LDATA;
         S_LDATA:   state_in = S_FINISH;
         S_DCHECK: begin
            if (lvl_ff == '0 || left_ff != '0 || right_ff != '0 || valid_ff)
               state_in = S_FINISH;
            else
               state_in = S_DPARENT;
         end
         S_DPARENT: state_in = S_DPEVAL;
         S_DPEVAL:  state_in = S_DCHECK;
         S_FINISH:  if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in = op_ff; addr_in = addr_ff; mask_in = mask_ff; hop_in = hop_ff;
      lvl_in = lvl_ff; cur_in = cur_ff; best_in = best_ff; new_in = new_ff;
      cnt_in = cnt_ff; clr_in = clr_ff; hit_in = hit_ff;
      left_in = left_ff; right_in = right_ff; valid_in = valid_ff;
      res_status_in = res_status_ff; res_found_in = res_found_ff;
      res_pfx_in = res_pfx_ff; res_mask_in = res_mask_ff; res_hop_in = res_hop_ff;
      out_status_in = out_status_ff; out_found_in = out_found_ff;
      out_pfx_in = out_pfx_ff; out_mask_in = out_mask_ff; out_hop_in = out_hop_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;

      node_we = 1'b0; node_waddr = cur_ff; node_wdata = {left_ff, right_ff, valid_ff};
      node_raddr = cur_ff;
      route_we = 1'b0; route_wdata = {addr_ff & mask_ff, mask_ff, hop_ff};
      stack_we = 1'b0; stack_waddr = cnt_ff; stack_raddr = cnt_ff - IW'(1);
      stack_wdata = cur_ff;
      path_we = 1'b0; path_waddr = lvl_ff[4:0]; path_raddr = lvl_ff[4:0] - 5'd1;

      case (state_ff)
         // zero the node memory and fill the free stack
         S_CLEAR: begin
            node_we = 1'b1; node_waddr = clr_ff; node_wdata = '0;
            stack_we = 1'b1; stack_waddr = clr_ff;
            stack_wdata = IW'(NODE_COUNT - 1) - clr_ff;
            clr_in = clr_ff + IW'(1);
         end
         // take a request beat and start at the root
         S_IDLE: begin
            op_in = req_chan.req_type; addr_in = req_chan.address;
            mask_in = req_chan.net_mask; hop_in = req_chan.hop_tag;
            lvl_in = '0; cur_in = '0; best_in = '0; hit_in = 1'b0;
            node_raddr = '0;
            res_status_in = ST_NOT_FOUND; res_found_in = 1'b0;
            res_pfx_in = '0; res_mask_in = '0; res_hop_in = '0;
         end
         // one trie level per cycle, except where an insert must create a missing node
         S_EVAL: begin
            left_in = n_left; right_in = n_right; valid_in = n_valid;
            if (op_ff == OP_LOOKUP) begin
               if (n_valid) begin
                  best_in = cur_ff; hit_in = 1'b1;
               end
               if (!(end_look || child == '0)) begin
                  cur_in = child; lvl_in = lvl_ff + LVL_W'(1); node_raddr = child;
               end
            end else if (op_ff == OP_INSERT) begin
               if (end_route) begin
                  node_we = 1'b1; node_wdata = {n_left, n_right, 1'b1};
                  route_we = 1'b1; res_status_in = ST_OK;
               end else if (child != '0) begin
                  cur_in = child; lvl_in = lvl_ff + LVL_W'(1); node_raddr = child;
               end else if (cnt_ff == '0) begin
                  res_status_in = ST_FULL;
               end
            end else begin
               if (end_route) begin
                  if (n_valid) begin
                     node_we = 1'b1; node_wdata = {n_left, n_right, 1'b0};
                     valid_in = 1'b0;
                  end
               end else begin
                  path_we = 1'b1;
                  if (child != '0) begin
                     cur_in = child; lvl_in = lvl_ff + LVL_W'(1); node_raddr = child;
                  end
               end
            end
         end
         // pop a free node and hang it below the current one
         S_LINK: begin
            new_in = stack_rdata; cnt_in = cnt_ff - IW'(1);
            node_we = 1'b1;
            node_wdata = dir_bit ? {left_ff, stack_rdata, valid_ff}
                                 : {stack_rdata, right_ff, valid_ff};
         end
         S_INIT: begin
            node_we = 1'b1; node_waddr = new_ff; node_wdata = '0;
            cur_in = new_ff; lvl_in = lvl_ff + LVL_W'(1);
         end
         S_LDATA: begin
            res_status_in = ST_OK; res_found_in = 1'b1;
            {res_pfx_in, res_mask_in, res_hop_in} = route_rdata;
         end
         // prune upward: free an empty node and fetch its parent
         S_DCHECK: begin
            if (lvl_ff == '0 || left_ff != '0 || right_ff != '0 || valid_ff) begin
               res_status_in = ST_OK;
            end else begin
               stack_we = 1'b1; cnt_in = cnt_ff + IW'(1);
            end
         end
         S_DPARENT: begin
            cur_in = path_rdata; node_raddr = path_rdata; lvl_in = lvl_ff - LVL_W'(1);
         end
         S_DPEVAL: begin
            left_in = dir_bit ? n_left : '0;
            right_in = dir_bit ? '0 : n_right;
            valid_in = n_valid;
            node_we = 1'b1;
            node_wdata = dir_bit ? {n_left, {IW{1'b0}}, n_valid}
                                 : {{IW{1'b0}}, n_right, n_valid};
         end
         // hand the result to the output register
         S_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_status_in = res_status_ff; out_found_in = res_found_ff;
               out_pfx_in = res_pfx_ff; out_mask_in = res_mask_ff; out_hop_in = res_hop_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= IW'(NODE_COUNT - 1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; addr_ff <= addr_in; mask_ff <= mask_in; hop_ff <= hop_in;
      lvl_ff <= lvl_in; cur_ff <= cur_in; best_ff <= best_in; new_ff <= new_in;
      hit_ff <= hit_in; left_ff <= left_in; right_ff <= right_in; valid_ff <= valid_in;
      res_status_ff <= res_status_in; res_found_ff <= res_found_in;
      res_pfx_ff <= res_pfx_in; res_mask_ff <= res_mask_in; res_hop_ff <= res_hop_in;
      out_status_ff <= out_status_in; out_found_ff <= out_found_in;
      out_pfx_ff <= out_pfx_in; out_mask_ff <= out_mask_in; out_hop_ff <= out_hop_in;
   end
endmodule

// File: rtl/lpt_checker.sv
// Port-level checks for the prefix trie, bound to the top level.
// Depends on lpt_pkg for status codes.
module lpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_found,
   input logic [31:0] rsp_prefix,
   input logic [31:0] rsp_mask,
   input logic [31:0] rsp_hop
);
   import lpt_pkg::*;

   // a response beat is held until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped before it was taken");

   // a match always reports ok
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK)
      else $error("match reported with a failing status");

   // without a match the route fields are zero
   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_prefix == 0 && rsp_mask == 0 && rsp_hop == 0)
      else $error("route fields set without a match");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");
endmodule

bind ipv4_longest_prefix_trie_top lpt_checker u_lpt_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status), .rsp_found(rsp_chan.found),
   .rsp_prefix(rsp_chan.match_prefix), .rsp_mask(rsp_chan.match_mask),
   .rsp_hop(rsp_chan.match_hop));
